/* sv/pnc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnc_pkg - shared definitions for the palette remap block
// Widths, op codes, register map and the core status bundle.
// ----------------------------------------------------------------------------
package pnc_pkg;

    localparam int SRC_ENTRIES        = 256;
    localparam int TARGET_ENTRIES_DEF = 256;
    localparam int COLOR_W            = 8;
    localparam int RGB_W              = 3 * COLOR_W;
    localparam int ACT_W              = 9;
    localparam int OP_W               = 2;

    // distance of three 8-bit channels fits in 18 bits; start value needs 19
    localparam int DIST_W = 19;
    localparam logic [DIST_W-1:0] DIST_START = DIST_W'(256 * 256 * 4);

    localparam logic [OP_W-1:0] OP_WR_SRC  = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_TGT  = 2'd1;
    localparam logic [OP_W-1:0] OP_CONVERT = 2'd2;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_ACTIVE_COLORS = 1'b0;

    typedef struct packed {
        logic               idle;
        logic               res_valid;
        logic [COLOR_W-1:0] res_index;
    } pnc_status_t;

endpackage

/* sv/pnc_dist_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnc_dist_unit - squared RGB distance unit
// One registered distance per cycle for the target entry being scanned.
// ----------------------------------------------------------------------------
module pnc_dist_unit
    import pnc_pkg::*;
#(
    parameter int IDX_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic              flush,
    input  logic [IDX_W-1:0]  in_idx,
    input  logic [RGB_W-1:0]  src_rgb,
    input  logic [RGB_W-1:0]  tgt_rgb,
    output logic              out_valid,
    output logic [IDX_W-1:0]  out_idx,
    output logic [DIST_W-1:0] out_dist
);

    logic              valid_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] dist_next;

    function automatic logic [2*COLOR_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                                     input logic [COLOR_W-1:0] b);
        logic [COLOR_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d * d;
    endfunction

    always_comb begin
        dist_next = DIST_W'(sq_diff(src_rgb[23:16], tgt_rgb[23:16]))
                  + DIST_W'(sq_diff(src_rgb[15:8],  tgt_rgb[15:8]))
                  + DIST_W'(sq_diff(src_rgb[7:0],   tgt_rgb[7:0]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid && !flush;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= in_idx;
        dist_reg <= dist_next;
    end

    assign out_valid = valid_reg;
    assign out_idx   = idx_reg;
    assign out_dist  = dist_reg;

endmodule

/* sv/pnc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnc_core - palette stores and search sequencer
// Holds both palettes, streams target entries through the distance unit and
// keeps the running best entry.
// ----------------------------------------------------------------------------
module pnc_core
    import pnc_pkg::*;
#(
    parameter int TARGET_ENTRIES = TARGET_ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_accept,
    input  logic [OP_W-1:0]    cmd_op,
    input  logic [COLOR_W-1:0] cmd_index,
    input  logic [RGB_W-1:0]   cmd_rgb,
    input  logic [ACT_W-1:0]   active_colors,
    input  logic               res_ack,
    output pnc_status_t        status
);

    localparam int TADDR_W = (TARGET_ENTRIES > 1) ? $clog2(TARGET_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(TARGET_ENTRIES + 1);
    localparam int SAT_W   = (CNT_W > ACT_W) ? CNT_W : ACT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [RGB_W-1:0] src_mem [SRC_ENTRIES];
    logic [RGB_W-1:0] tgt_mem [TARGET_ENTRIES];
    logic [RGB_W-1:0] src_rdata_reg;
    logic [RGB_W-1:0] tgt_rdata_reg;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   iss_reg, iss_next;
    logic               v1_reg, v1_next;
    logic [TADDR_W-1:0] idx1_reg;
    logic [TADDR_W-1:0] best_idx_reg, best_idx_next;
    logic [DIST_W-1:0]  best_dist_reg, best_dist_next;

    logic               convert;
    logic               tgt_in_range;
    logic               rd_en;
    logic [TADDR_W-1:0] rd_addr;
    logic [SAT_W-1:0]   act_ext;
    logic [CNT_W-1:0]   cnt_sat;

    logic               d_valid;
    logic [TADDR_W-1:0] d_idx;
    logic [DIST_W-1:0]  d_dist;
    logic               take;
    logic               last;
    logic               finish;

    assign convert      = cmd_accept && (cmd_op == OP_CONVERT);
    assign tgt_in_range = (32'(cmd_index) < 32'(TARGET_ENTRIES));
    assign act_ext      = SAT_W'(active_colors);
    assign cnt_sat      = (act_ext > SAT_W'(TARGET_ENTRIES)) ? CNT_W'(TARGET_ENTRIES)
                                                             : CNT_W'(act_ext);

    // palette writes and the source lookup
    always_ff @(posedge aclk) begin
        if (cmd_accept && (cmd_op == OP_WR_SRC)) begin
            src_mem[cmd_index] <= cmd_rgb;
        end
        if (convert) begin
            src_rdata_reg <= src_mem[cmd_index];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_accept && (cmd_op == OP_WR_TGT) && tgt_in_range) begin
            tgt_mem[TADDR_W'(cmd_index)] <= cmd_rgb;
        end
        if (rd_en) begin
            tgt_rdata_reg <= tgt_mem[rd_addr];
        end
    end

    pnc_dist_unit #(
        .IDX_W(TADDR_W)
    ) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (v1_reg),
        .flush    (finish),
        .in_idx   (idx1_reg),
        .src_rgb  (src_rdata_reg),
        .tgt_rgb  (tgt_rdata_reg),
        .out_valid(d_valid),
        .out_idx  (d_idx),
        .out_dist (d_dist)
    );

    // strict less keeps the lowest index on a tie
    assign take   = d_valid && (d_dist < best_dist_reg);
    assign last   = d_valid && ((CNT_W'(d_idx) + CNT_W'(1)) == cnt_reg);
    assign finish = (state_reg == ST_SCAN) && (last || (take && (d_dist == '0)));

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        iss_next       = iss_reg;
        v1_next        = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = iss_reg[TADDR_W-1:0];
        best_idx_next  = take ? d_idx : best_idx_reg;
        best_dist_next = take ? d_dist : best_dist_reg;
        case (state_reg)
            ST_IDLE: begin
                best_idx_next  = '0;
                best_dist_next = DIST_START;
                if (convert) begin
                    cnt_next = cnt_sat;
                    if (cnt_sat == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        v1_next    = 1'b1;
                        iss_next   = CNT_W'(1);
                    end
                end
            end
            ST_SCAN: begin
                if (finish) begin
                    state_next = ST_DONE;
                end else if (iss_reg < cnt_reg) begin
                    rd_en    = 1'b1;
                    v1_next  = 1'b1;
                    iss_next = iss_reg + CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (res_ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            v1_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        iss_reg       <= iss_next;
        idx1_reg      <= rd_addr;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
    end

    assign status.idle      = (state_reg == ST_IDLE);
    assign status.res_valid = (state_reg == ST_DONE);
    assign status.res_index = COLOR_W'(best_idx_reg);

endmodule

/* sv/palette_nearest_color_remap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_nearest_color_remap - nearest palette colour remapper
// Maps indexed pixels to the closest entry of a target RGB palette.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per handshake. op 0 loads a source palette entry,
//   op 1 a target palette entry, op 2 converts the pixel in s_index; op 3
//   is dropped. Palette writes leave s_ready high and give no result.
//   m_ channel: one m_color_index item per convert.
//   APB register 0 (active_colors) sets how many target entries are searched.
// Timing:
//   A convert streams the active target entries through one squared-distance
//   unit, one entry per cycle, from the target store; a registered store read
//   feeds the distance register and then the best-entry compare. With none
//   active the search is skipped, and it ends early on an exact match; the
//   result then moves into the output register, which drives m_valid.
//   s_ready stays low for the whole search.
//   The output register lets the next item in while a result waits; a
//   stalled m_ready only holds the block once a second result is ready.
// Reset: clears the control state and active_colors; palette contents are
//   undefined until written.
// ----------------------------------------------------------------------------
module palette_nearest_color_remap
    import pnc_pkg::*;
#(
    parameter int TARGET_ENTRIES = TARGET_ENTRIES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_op,
    input  logic [COLOR_W-1:0]    s_index,
    input  logic [COLOR_W-1:0]    s_red,
    input  logic [COLOR_W-1:0]    s_green,
    input  logic [COLOR_W-1:0]    s_blue,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COLOR_W-1:0]    m_color_index,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [ACT_W-1:0]   active_colors_reg;
    logic               m_valid_reg, m_valid_next;
    logic [COLOR_W-1:0] m_color_index_reg;
    logic               cmd_accept;
    logic               res_ack;
    logic               reg_sel;
    pnc_status_t        status;

    assign reg_sel    = (paddr[2] == REG_ACTIVE_COLORS);
    assign cmd_accept = s_valid && s_ready;
    assign s_ready    = status.idle;
    assign res_ack    = status.res_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_colors_reg <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            active_colors_reg <= pwdata[ACT_W-1:0];
        end
    end

    assign prdata = reg_sel ? APB_DATA_W'(active_colors_reg) : '0;
    assign pready = 1'b1;

    pnc_core #(
        .TARGET_ENTRIES(TARGET_ENTRIES)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_accept   (cmd_accept),
        .cmd_op       (s_op),
        .cmd_index    (s_index),
        .cmd_rgb      ({s_red, s_green, s_blue}),
        .active_colors(active_colors_reg),
        .res_ack      (res_ack),
        .status       (status)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ack) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ack) begin
            m_color_index_reg <= status.res_index;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_color_index = m_color_index_reg;

endmodule

/* sv/pnc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnc_checker - port-level checks for the palette remapper
// Watches the item channels and the APB port of the top level.
// ----------------------------------------------------------------------------
module pnc_checker
    import pnc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [OP_W-1:0]    s_op,
    input logic               m_valid,
    input logic               m_ready,
    input logic [COLOR_W-1:0] m_color_index,
    input logic               pready
);

    // a convert item always takes s_ready low once it is accepted
    a_convert_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_CONVERT) |=> !s_ready)
        else $error("s_ready high right after a convert item");

    // palette writes and dropped ops never hold the input side
    a_write_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op != OP_CONVERT) |=> s_ready)
        else $error("s_ready dropped after a palette write");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_color_index))
        else $error("result item changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset left an item pending");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind palette_nearest_color_remap pnc_checker u_pnc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_op         (s_op),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_color_index(m_color_index),
    .pready       (pready)
);

/* sim/tb_palette_nearest_color_remap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_nearest_color_remap - self-checking bench for the palette remap
// Loads source and target palettes, converts pixels under a sweep of
// active_colors settings and checks every colour index against a behavioural
// nearest-colour search, with random idling on both item channels.
// ----------------------------------------------------------------------------
module tb_palette_nearest_color_remap;
    import pnc_pkg::*;

    localparam int TGT_ENTRIES = TARGET_ENTRIES_DEF;
    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ADDR_ACTIVE = APB_ADDR_W'(4 * REG_ACTIVE_COLORS);
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = APB_ADDR_W'(4);
    localparam int MAX_GAP = 19;
    localparam int SETTLE_CYCLES = 280;
    localparam int HOLD_CYCLES = 1500;
    localparam int ITEMS_PER_PHASE = 100;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COLOR_W-1:0] index;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } remap_item_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [OP_W-1:0]       s_op = '0;
    logic [COLOR_W-1:0]    s_index = '0;
    logic [COLOR_W-1:0]    s_red = '0;
    logic [COLOR_W-1:0]    s_green = '0;
    logic [COLOR_W-1:0]    s_blue = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [COLOR_W-1:0]    m_color_index;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state, updated as items are accepted
    logic [RGB_W-1:0]   src_rgb [SRC_ENTRIES];
    logic [RGB_W-1:0]   tgt_rgb [TGT_ENTRIES];
    logic [ACT_W-1:0]   active_setting = '0;
    logic [COLOR_W-1:0] expected_colors [$];

    // what the stimulus has scheduled so far, so that no unwritten entry is read
    bit                 plan_src_ok [SRC_ENTRIES];
    bit                 plan_tgt_ok [TGT_ENTRIES];
    logic [RGB_W-1:0]   plan_tgt_rgb [TGT_ENTRIES];

    remap_item_t        pending_items [$];
    remap_item_t        drive_item;
    logic [COLOR_W-1:0] want_index;
    int                 items_queued = 0;
    int                 items_accepted = 0;
    int                 colors_checked = 0;
    int                 error_count = 0;
    int                 send_gap = 0;
    int                 hold_left = 0;
    bit                 send_burst = 1'b0;
    bit                 take_burst = 1'b0;

    palette_nearest_color_remap uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_index       (s_index),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_color_index (m_color_index),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(30_000_000);
        $display("tb: failure");
        $finish;
    end

    // least squared RGB distance over the active target entries, lowest index on a tie
    function automatic logic [COLOR_W-1:0] nearest_entry(input logic [RGB_W-1:0] rgb);
        int limit, best_dist, sq_dist, dr, dg, db;
        logic [COLOR_W-1:0] best;
        limit = (active_setting > TGT_ENTRIES) ? TGT_ENTRIES : int'(active_setting);
        best_dist = 256 * 256 * 4;
        best = '0;
        for (int k = 0; k < limit; k++) begin
            dr = int'(rgb[23:16]) - int'(tgt_rgb[k][23:16]);
            dg = int'(rgb[15:8]) - int'(tgt_rgb[k][15:8]);
            db = int'(rgb[7:0]) - int'(tgt_rgb[k][7:0]);
            sq_dist = dr * dr + dg * dg + db * db;
            if (sq_dist < best_dist) begin
                best_dist = sq_dist;
                best = COLOR_W'(k);
                if (sq_dist == 0) break;
            end
        end
        return best;
    endfunction

    // item driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                case (drive_item.op)
                    OP_WR_SRC: begin
                        src_rgb[drive_item.index] =
                            {drive_item.red, drive_item.green, drive_item.blue};
                    end
                    OP_WR_TGT: begin
                        if (drive_item.index < TGT_ENTRIES)
                            tgt_rgb[drive_item.index] =
                                {drive_item.red, drive_item.green, drive_item.blue};
                    end
                    OP_CONVERT: begin
                        expected_colors.push_back(nearest_entry(src_rgb[drive_item.index]));
                    end
                    default: ;
                endcase
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    drive_item = pending_items.pop_front();
                    s_op    <= drive_item.op;
                    s_index <= drive_item.index;
                    s_red   <= drive_item.red;
                    s_green <= drive_item.green;
                    s_blue  <= drive_item.blue;
                    s_valid <= 1'b1;
                    if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_colors.size() == 0) begin
                    $display("%0t: unexpected colour index %0d", $time, m_color_index);
                    error_count++;
                end else begin
                    want_index = expected_colors.pop_front();
                    if (m_color_index !== want_index) begin
                        $display("%0t: colour index mismatch: expected %0d, got %0d",
                                 $time, want_index, m_color_index);
                        error_count++;
                    end
                end
                colors_checked++;
                // long hold-offs so the block backs up onto its input
                if (colors_checked == 120 || colors_checked == 450) begin
                    hold_left = HOLD_CYCLES;
                end else begin
                    if ($urandom_range(0, 63) == 0) take_burst = !take_burst;
                    hold_left = take_burst ? 0 : $urandom_range(0, MAX_GAP);
                end
            end else if (hold_left > 0) begin
                hold_left--;
            end
            m_ready <= (hold_left == 0);
        end
    end

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_ACTIVE) active_setting = data[ACT_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic enqueue_op(input logic [OP_W-1:0] op, input logic [COLOR_W-1:0] idx,
                              input logic [RGB_W-1:0] rgb);
        remap_item_t it;
        it.op    = op;
        it.index = idx;
        it.red   = rgb[23:16];
        it.green = rgb[15:8];
        it.blue  = rgb[7:0];
        pending_items.push_back(it);
        items_queued++;
        if (op == OP_WR_SRC) begin
            plan_src_ok[idx] = 1'b1;
        end else if (op == OP_WR_TGT && idx < TGT_ENTRIES) begin
            plan_tgt_ok[idx] = 1'b1;
            plan_tgt_rgb[idx] = rgb;
        end
    endtask

    // copies of target colours give exact matches and ties
    function automatic logic [RGB_W-1:0] pick_rgb();
        int sel, k;
        logic [2:0] full;
        sel = $urandom_range(0, 9);
        k = $urandom_range(0, TGT_ENTRIES - 1);
        full = 3'($urandom);
        if (sel < 3 && plan_tgt_ok[k]) return plan_tgt_rgb[k];
        if (sel < 5) return {{8{full[2]}}, {8{full[1]}}, {8{full[0]}}};
        return RGB_W'($urandom);
    endfunction

    function automatic logic [COLOR_W-1:0] pick_src();
        int k;
        k = $urandom_range(0, SRC_ENTRIES - 1);
        for (int n = 0; n < SRC_ENTRIES; n++) begin
            if (plan_src_ok[(k + n) % SRC_ENTRIES]) return COLOR_W'((k + n) % SRC_ENTRIES);
        end
        return '0;
    endfunction

    task automatic wait_drained();
        while (items_accepted != items_queued || expected_colors.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phase(input int active);
        int sel;
        logic [COLOR_W-1:0] idx;
        logic [RGB_W-1:0] rgb;
        apb_write(ADDR_ACTIVE, APB_DATA_W'(active));
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            sel = $urandom_range(0, 99);
            idx = COLOR_W'($urandom);
            rgb = pick_rgb();
            if (sel < 55) begin
                enqueue_op(OP_CONVERT, pick_src(), RGB_W'($urandom));
            end else if (sel < 78) begin
                enqueue_op(OP_WR_TGT, idx, rgb);
            end else if (sel < 94) begin
                enqueue_op(OP_WR_SRC, idx, rgb);
                if (sel < 88) enqueue_op(OP_CONVERT, idx, RGB_W'($urandom));
            end else begin
                enqueue_op(OP_IGNORED, idx, RGB_W'($urandom));
            end
        end
        wait_drained();
    endtask

    initial begin
        int perm_t [TGT_ENTRIES];
        int perm_s [SRC_ENTRIES];
        int phase_active [9];
        int j, tmp;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        apb_write(ADDR_ACTIVE, '0);
        enqueue_op(OP_WR_SRC, 8'd0, 24'h000000);
        enqueue_op(OP_WR_SRC, 8'hff, 24'hffffff);
        enqueue_op(OP_WR_SRC, 8'd1, 24'hff0080);
        enqueue_op(OP_WR_TGT, 8'd0, 24'hffffff);
        enqueue_op(OP_WR_TGT, 8'd1, 24'h000000);
        enqueue_op(OP_WR_TGT, 8'd2, 24'h000000);
        // nothing searched yet: entry zero comes back
        enqueue_op(OP_CONVERT, 8'd0, 24'hffffff);
        enqueue_op(OP_CONVERT, 8'hff, 24'h000000);
        enqueue_op(OP_IGNORED, 8'hff, 24'hffffff);
        enqueue_op(OP_IGNORED, 8'd0, 24'h000000);
        wait_drained();

        apb_write(ADDR_ACTIVE, APB_DATA_W'(3));
        // no register here, active_colors must stay at 3
        apb_write(ADDR_SPARE, APB_DATA_W'(1));
        // black sits at entries 1 and 2, the first copy wins
        enqueue_op(OP_CONVERT, 8'd0, 24'h000000);
        enqueue_op(OP_CONVERT, 8'hff, 24'h000000);
        enqueue_op(OP_CONVERT, 8'd1, 24'h000000);
        enqueue_op(OP_WR_SRC, 8'd2, 24'h7f7f7f);
        enqueue_op(OP_CONVERT, 8'd2, 24'hffffff);
        enqueue_op(OP_WR_TGT, 8'd2, 24'hff0080);
        enqueue_op(OP_CONVERT, 8'd1, 24'h000000);
        enqueue_op(OP_IGNORED, 8'd1, 24'h123456);
        enqueue_op(OP_CONVERT, 8'd1, 24'hffffff);
        wait_drained();

        // fill both palettes in random order with converts mixed in
        for (int k = 0; k < TGT_ENTRIES; k++) perm_t[k] = k;
        for (int k = 0; k < SRC_ENTRIES; k++) perm_s[k] = k;
        for (int k = TGT_ENTRIES - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = perm_t[k];
            perm_t[k] = perm_t[j];
            perm_t[j] = tmp;
            j = $urandom_range(0, k);
            tmp = perm_s[k];
            perm_s[k] = perm_s[j];
            perm_s[j] = tmp;
        end
        for (int k = 0; k < TGT_ENTRIES; k++) begin
            enqueue_op(OP_WR_TGT, COLOR_W'(perm_t[k]), pick_rgb());
            enqueue_op(OP_WR_SRC, COLOR_W'(perm_s[k]), pick_rgb());
            if ($urandom_range(0, 4) < 2) enqueue_op(OP_CONVERT, pick_src(), RGB_W'($urandom));
        end
        wait_drained();

        phase_active = '{TGT_ENTRIES, (1 << ACT_W) - 1, 1, 255, 0,
                         $urandom_range(2, 254), 128, TGT_ENTRIES,
                         $urandom_range(0, TGT_ENTRIES)};
        foreach (phase_active[p]) random_phase(phase_active[p]);

        $display("tb: %0d items accepted, %0d colour indexes checked, %0d mismatches",
                 items_accepted, colors_checked, error_count);
        $display("tb: active_colors swept over 0, 1, 3, 128, 255, 256, 511 and random values");
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* files.f */
sv/pnc_pkg.sv
sv/pnc_dist_unit.sv
sv/pnc_core.sv
sv/palette_nearest_color_remap.sv
sv/pnc_checker.sv
sim/tb_palette_nearest_color_remap.sv
